/* sv/mqrw_pkg.sv */
// Shared types and constants for the multi-queue ring writer.
// Used by mqrw_table, mqrw_csr and multi_queue_ring_writer_unit; no dependencies.
`default_nettype none

package mqrw_pkg;

   // Queue and ring geometry
   localparam int QUEUES    = 8;
   localparam int SLOTS     = 64;
   localparam int MSG_BYTES = 4096;

   // Field widths
   localparam int QID_W   = 3;
   localparam int IDX_W   = 8;
   localparam int DATA_W  = 64;
   localparam int ADDR_W  = 64;
   localparam int CNT_W   = 32;
   localparam int TBL_DEPTH = 1 << QID_W;

   // Slot offset product width: slot index times message size
   localparam int MSG_W  = $clog2(MSG_BYTES + 1);
   localparam int PROD_W = IDX_W + MSG_W;

   // Register file: eight 64-bit base registers at 8-byte spacing
   localparam int NUM_REGS = 8;
   localparam int PADDR_W  = 6;
   localparam int PDATA_W  = 64;
   localparam int REG_LSB  = 3;

   typedef enum logic {
      OP_MSG  = 1'b0,
      OP_HEAD = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_FWD  = 2'd0,
      STAT_HELD = 2'd1,
      STAT_BUSY = 2'd2,
      STAT_NONE = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Access request to one index table
   typedef struct packed {
      logic             rd_en;
      logic [QID_W-1:0] rd_addr;
      logic             wr_en;
      logic [QID_W-1:0] wr_addr;
      logic [IDX_W-1:0] wr_data;
   } tbl_req_type;

endpackage

`default_nettype wire

/* sv/mqrw_table.sv */
// Per-queue index table (tail or head): synchronous memory, one read and one write port.
// Entries read as zero until first written. Depends on mqrw_pkg.
`default_nettype none

module mqrw_table (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mqrw_pkg::tbl_req_type   req,
   output logic [mqrw_pkg::IDX_W-1:0]   rd_data
);

   logic [mqrw_pkg::IDX_W-1:0]     mem_ff [mqrw_pkg::TBL_DEPTH];
   logic [mqrw_pkg::TBL_DEPTH-1:0] vld_ff;
   logic [mqrw_pkg::IDX_W-1:0]     rd_data_ff;
   logic                           rd_vld_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem_ff[req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            vld_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_vld_ff <= vld_ff[req.rd_addr];
         end
      end
   end

   // unwritten entries read as reset value
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

/* sv/mqrw_csr.sv */
// Base address register file behind the APB-style port, kept in a two-read-port memory.
// Port A serves bus reads, port B serves the datapath. Depends on mqrw_pkg.
`default_nettype none

module mqrw_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [mqrw_pkg::PADDR_W-1:0]  csr_paddr,
   input  wire logic [mqrw_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic [mqrw_pkg::PDATA_W-1:0]       csr_prdata,
   output logic                               csr_pready,
   input  wire logic                          base_rd_en,
   input  wire logic [mqrw_pkg::QID_W-1:0]    base_rd_addr,
   output logic [mqrw_pkg::ADDR_W-1:0]        base_rd_data
);

   logic [mqrw_pkg::ADDR_W-1:0]   mem_ff [mqrw_pkg::NUM_REGS];
   logic [mqrw_pkg::NUM_REGS-1:0] vld_ff;
   logic [mqrw_pkg::ADDR_W-1:0]   bus_rd_ff;
   logic                          bus_vld_ff;
   logic [mqrw_pkg::ADDR_W-1:0]   dp_rd_ff;
   logic                          dp_vld_ff;
   logic                          wr_en;
   logic [mqrw_pkg::QID_W-1:0]    reg_idx;

   assign reg_idx    = csr_paddr[mqrw_pkg::REG_LSB +: mqrw_pkg::QID_W];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // bus read is sampled during setup, so data is ready in the access phase
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[reg_idx] <= csr_pwdata;
      end
      bus_rd_ff <= mem_ff[reg_idx];
      if (base_rd_en) begin
         dp_rd_ff <= mem_ff[base_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         bus_vld_ff <= 1'b0;
         dp_vld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[reg_idx] <= 1'b1;
         end
         bus_vld_ff <= vld_ff[reg_idx];
         if (base_rd_en) begin
            dp_vld_ff <= vld_ff[base_rd_addr];
         end
      end
   end

   assign csr_prdata   = bus_vld_ff ? bus_rd_ff : '0;
   assign base_rd_data = dp_vld_ff ? dp_rd_ff : '0;

endmodule

`default_nettype wire

/* sv/multi_queue_ring_writer_unit.sv */
// Multi-queue ring writer top level: request/response channels, tables, pending slot.
// Depends on mqrw_pkg, mqrw_table and mqrw_csr.
`default_nettype none

// Places messages into per-queue circular buffers in host memory. Each request
// transaction is either a message (opcode 0) or a consumer head update (opcode 1);
// every request yields exactly one response transaction carrying a status, the
// slot's host address (base + tail * MSG_BYTES), the data, the queue and its tail.
// A message that would make the tail reach the head is held in a single pending
// slot and retried on each head update; other messages are refused while it waits.
// Tail and head indices live in small synchronous memories: a request reads them
// on the acceptance edge, and the exec state then computes the result and writes
// back once the response register is free. Requests are accepted only in idle, so
// a new one enters only after the previous update; the response register lets a new
// request enter while the previous response still waits. Base address
// registers sit behind the APB-style port at byte address 8 * queue.
module multi_queue_ring_writer_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [mqrw_pkg::QID_W-1:0]    req_queue,
   input  wire logic [mqrw_pkg::IDX_W-1:0]    req_head_index,
   input  wire logic [mqrw_pkg::DATA_W-1:0]   req_payload,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [mqrw_pkg::ADDR_W-1:0]        rsp_dma_addr,
   output logic [mqrw_pkg::DATA_W-1:0]        rsp_payload_out,
   output logic [mqrw_pkg::QID_W-1:0]         rsp_queue_out,
   output logic [mqrw_pkg::IDX_W-1:0]         rsp_tail_index,
   output logic [mqrw_pkg::CNT_W-1:0]         rsp_sent_count,
   // configuration port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [mqrw_pkg::PADDR_W-1:0]  csr_paddr,
   input  wire logic [mqrw_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic [mqrw_pkg::PDATA_W-1:0]       csr_prdata,
   output logic                               csr_pready
);

   localparam logic [mqrw_pkg::IDX_W-1:0]  LAST_SLOT = mqrw_pkg::IDX_W'(mqrw_pkg::SLOTS - 1);
   localparam logic [mqrw_pkg::QID_W:0]    NUM_Q     = (mqrw_pkg::QID_W + 1)'(mqrw_pkg::QUEUES);

   // state
   mqrw_pkg::state_type state_ff, state_in;

   // captured request transaction
   logic                          op_ff;
   logic [mqrw_pkg::QID_W-1:0]    q_ff;
   logic [mqrw_pkg::IDX_W-1:0]    head_in_ff;
   logic [mqrw_pkg::DATA_W-1:0]   data_ff;
   logic [mqrw_pkg::QID_W-1:0]    rq_ff;

   // pending slot and counter
   logic                          pend_vld_ff, pend_vld_in;
   logic [mqrw_pkg::DATA_W-1:0]   pend_data_ff, pend_data_in;
   logic [mqrw_pkg::QID_W-1:0]    pend_q_ff, pend_q_in;
   logic [mqrw_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   // response register
   logic                          rsp_vld_ff, rsp_vld_in;
   mqrw_pkg::status_type          rsp_stat_ff, rsp_stat_in;
   logic [mqrw_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [mqrw_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [mqrw_pkg::QID_W-1:0]    rsp_q_ff, rsp_q_in;
   logic [mqrw_pkg::IDX_W-1:0]    rsp_tail_ff, rsp_tail_in;

   // memory access
   mqrw_pkg::tbl_req_type         tail_req, head_req;
   logic [mqrw_pkg::IDX_W-1:0]    tail_rd, head_rd;
   logic [mqrw_pkg::ADDR_W-1:0]   base_rd;
   logic                          rd_en;
   logic [mqrw_pkg::QID_W-1:0]    rd_addr;

   // datapath
   logic                          accept;
   logic                          exec_go;
   logic                          qok;
   logic [mqrw_pkg::IDX_W-1:0]    head_eff;
   logic [mqrw_pkg::IDX_W-1:0]    next_tail;
   logic                          room;
   logic [mqrw_pkg::PROD_W-1:0]   slot_off;
   logic [mqrw_pkg::ADDR_W-1:0]   slot_addr;
   logic [mqrw_pkg::DATA_W-1:0]   try_data;
   logic                          do_try;

   mqrw_table u_tail (
      .clock   (clock),
      .reset   (reset),
      .req     (tail_req),
      .rd_data (tail_rd)
   );

   mqrw_table u_head (
      .clock   (clock),
      .reset   (reset),
      .req     (head_req),
      .rd_data (head_rd)
   );

   mqrw_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .base_rd_en   (rd_en),
      .base_rd_addr (rd_addr),
      .base_rd_data (base_rd)
   );

   // Accept only in idle; the update cycle always completes before the next read,
   // so no forwarding between transactions is needed.
   assign req_ready = (state_ff == mqrw_pkg::ST_IDLE);
   assign accept    = req_valid & req_ready;

   // A head update with a message pending reads the pending queue for the retry.
   assign rd_en   = accept;
   assign rd_addr = (req_opcode == mqrw_pkg::OP_HEAD && pend_vld_ff) ? pend_q_ff : req_queue;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_opcode;
         q_ff       <= req_queue;
         head_in_ff <= req_head_index;
         data_ff    <= req_payload;
         rq_ff      <= rd_addr;
      end
   end

   // Slot arithmetic on the entry just read
   always_comb begin
      qok = ({1'b0, q_ff} < NUM_Q);
      // a head update to the queue being retried takes effect first
      if (op_ff == mqrw_pkg::OP_HEAD && qok && q_ff == rq_ff) begin
         head_eff = head_in_ff;
      end else begin
         head_eff = head_rd;
      end
      next_tail = (tail_rd == LAST_SLOT) ? '0 : tail_rd + 1'b1;
      room      = (next_tail != head_eff);
      slot_off  = mqrw_pkg::PROD_W'(tail_rd) * mqrw_pkg::PROD_W'(mqrw_pkg::MSG_BYTES);
      slot_addr = base_rd + mqrw_pkg::ADDR_W'(slot_off);
      try_data  = (op_ff == mqrw_pkg::OP_HEAD) ? pend_data_ff : data_ff;
   end

   // Next state, write-back and response
   always_comb begin
      state_in     = state_ff;
      exec_go      = 1'b0;
      do_try       = 1'b0;
      pend_vld_in  = pend_vld_ff;
      pend_data_in = pend_data_ff;
      pend_q_in    = pend_q_ff;
      cnt_in       = cnt_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_q_in     = rsp_q_ff;
      rsp_tail_in  = rsp_tail_ff;
      rsp_vld_in   = rsp_vld_ff & ~rsp_ready;

      tail_req         = '0;
      tail_req.rd_en   = rd_en;
      tail_req.rd_addr = rd_addr;
      head_req         = '0;
      head_req.rd_en   = rd_en;
      head_req.rd_addr = rd_addr;

      unique case (state_ff)
         mqrw_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = mqrw_pkg::ST_EXEC;
            end
         end
         mqrw_pkg::ST_EXEC: begin
            // hold until the response register is free
            if (!rsp_vld_ff || rsp_ready) begin
               exec_go     = 1'b1;
               state_in    = mqrw_pkg::ST_IDLE;
               rsp_vld_in  = 1'b1;
               rsp_stat_in = mqrw_pkg::STAT_NONE;
               rsp_addr_in = '0;
               rsp_data_in = '0;
               rsp_q_in    = q_ff;
               rsp_tail_in = '0;

               if (op_ff == mqrw_pkg::OP_HEAD) begin
                  if (qok) begin
                     head_req.wr_en   = 1'b1;
                     head_req.wr_addr = q_ff;
                     head_req.wr_data = head_in_ff;
                  end
                  if (pend_vld_ff) begin
                     do_try = 1'b1;
                  end else if (qok) begin
                     rsp_tail_in = tail_rd;
                  end
               end else if (!qok) begin
                  rsp_stat_in = mqrw_pkg::STAT_NONE;
               end else if (pend_vld_ff) begin
                  rsp_stat_in = mqrw_pkg::STAT_BUSY;
                  rsp_tail_in = tail_rd;
               end else begin
                  do_try = 1'b1;
               end

               if (do_try) begin
                  rsp_q_in = rq_ff;
                  if (room) begin
                     // place: advance tail, release pending slot
                     rsp_stat_in      = mqrw_pkg::STAT_FWD;
                     rsp_addr_in      = slot_addr;
                     rsp_data_in      = try_data;
                     rsp_tail_in      = next_tail;
                     tail_req.wr_en   = 1'b1;
                     tail_req.wr_addr = rq_ff;
                     tail_req.wr_data = next_tail;
                     cnt_in           = cnt_ff + 1'b1;
                     pend_vld_in      = 1'b0;
                  end else begin
                     // ring full: hold the message
                     rsp_stat_in  = mqrw_pkg::STAT_HELD;
                     rsp_tail_in  = tail_rd;
                     pend_vld_in  = 1'b1;
                     pend_data_in = try_data;
                     pend_q_in    = rq_ff;
                  end
               end
            end
         end
         default: begin
            state_in = mqrw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mqrw_pkg::ST_IDLE;
         pend_vld_ff <= 1'b0;
         cnt_ff      <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
         cnt_ff      <= cnt_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_data_ff <= pend_data_in;
      pend_q_ff    <= pend_q_in;
      if (exec_go) begin
         rsp_stat_ff <= rsp_stat_in;
         rsp_addr_ff <= rsp_addr_in;
         rsp_data_ff <= rsp_data_in;
         rsp_q_ff    <= rsp_q_in;
         rsp_tail_ff <= rsp_tail_in;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_status      = rsp_stat_ff;
   assign rsp_dma_addr    = rsp_addr_ff;
   assign rsp_payload_out = rsp_data_ff;
   assign rsp_queue_out   = rsp_q_ff;
   assign rsp_tail_index  = rsp_tail_ff;
   assign rsp_sent_count  = cnt_ff;

endmodule

`default_nettype wire

/* test/multi_queue_ring_writer_unit_tb.sv */
// Self-checking testbench for multi_queue_ring_writer_unit: drives request transactions
// and base address writes, checks every response against an in-bench ring predictor.
// Depends on mqrw_pkg and the multi_queue_ring_writer_unit RTL only.

module multi_queue_ring_writer_unit_tb;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int          PHASE_ITEMS   = 275;
   localparam int          PHASES        = 6;
   localparam int          SETTLE_CYCLES = 6;

   // Base address register settings applied between phases
   typedef enum int {
      BASES_RANDOM,
      BASES_ZERO,
      BASES_ONES,
      BASES_WRAP,
      BASES_MIXED
   } base_pattern_type;

   // One response transaction, as predicted or as seen on the port
   typedef struct packed {
      mqrw_pkg::status_type          status;
      logic [mqrw_pkg::ADDR_W-1:0]   dma_addr;
      logic [mqrw_pkg::DATA_W-1:0]   payload;
      logic [mqrw_pkg::QID_W-1:0]    queue;
      logic [mqrw_pkg::IDX_W-1:0]    tail;
      logic [mqrw_pkg::CNT_W-1:0]    sent;
   } ring_result_type;

   // Ring state predictor plus the ordered list of responses still owed by the block
   class slot_scoreboard_type;
      logic [mqrw_pkg::ADDR_W-1:0] base [mqrw_pkg::TBL_DEPTH];
      logic [mqrw_pkg::IDX_W-1:0]  tail [mqrw_pkg::TBL_DEPTH];
      logic [mqrw_pkg::IDX_W-1:0]  head [mqrw_pkg::TBL_DEPTH];
      bit                          msg_held;
      logic [mqrw_pkg::DATA_W-1:0] held_data;
      logic [mqrw_pkg::QID_W-1:0]  held_queue;
      logic [mqrw_pkg::CNT_W-1:0]  fwd_count;
      ring_result_type             expected_slots[$];
      int                          errors;

      function new();
         for (int i = 0; i < mqrw_pkg::TBL_DEPTH; i++) begin
            base[i] = '0;
            tail[i] = '0;
            head[i] = '0;
         end
         msg_held   = 1'b0;
         held_data  = '0;
         held_queue = '0;
         fwd_count  = '0;
         errors     = 0;
      endfunction

      function int outstanding();
         return expected_slots.size();
      endfunction

      // Place a message at the queue's tail, or hold it when the ring is full
      function void place(logic [mqrw_pkg::QID_W-1:0] q, logic [mqrw_pkg::DATA_W-1:0] data,
                          inout ring_result_type r);
         logic [mqrw_pkg::IDX_W-1:0] t;
         logic [mqrw_pkg::IDX_W-1:0] nt;
         t  = tail[q];
         nt = (t == mqrw_pkg::IDX_W'(mqrw_pkg::SLOTS - 1)) ? '0 : t + 1'b1;
         r.queue = q;
         if (nt != head[q]) begin
            r.status   = mqrw_pkg::STAT_FWD;
            r.dma_addr = base[q] + mqrw_pkg::ADDR_W'(mqrw_pkg::MSG_BYTES)
                                 * mqrw_pkg::ADDR_W'(t);
            r.payload  = data;
            r.tail     = nt;
            tail[q]    = nt;
            fwd_count  = fwd_count + 1'b1;
            msg_held   = 1'b0;
         end else begin
            r.status   = mqrw_pkg::STAT_HELD;
            r.tail     = t;
            msg_held   = 1'b1;
            held_data  = data;
            held_queue = q;
         end
      endfunction

      function void note_request(mqrw_pkg::opcode_type op, logic [mqrw_pkg::QID_W-1:0] q,
                                 logic [mqrw_pkg::IDX_W-1:0] hidx,
                                 logic [mqrw_pkg::DATA_W-1:0] data);
         ring_result_type r;
         r.status   = mqrw_pkg::STAT_NONE;
         r.dma_addr = '0;
         r.payload  = '0;
         r.queue    = q;
         r.tail     = '0;
         if (op == mqrw_pkg::OP_HEAD) begin
            head[q] = hidx;
            // a head move retries whatever message is waiting, on its own queue
            if (msg_held) place(held_queue, held_data, r);
            else r.tail = tail[q];
         end else if (msg_held) begin
            r.status = mqrw_pkg::STAT_BUSY;
            r.tail   = tail[q];
         end else begin
            place(q, data, r);
         end
         if (r.status != mqrw_pkg::STAT_FWD) begin
            r.dma_addr = '0;
            r.payload  = '0;
         end
         r.sent = fwd_count;
         expected_slots.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_response(ring_result_type act);
         ring_result_type want;
         if (expected_slots.size() == 0) begin
            errors++;
            $display("%0t: response with nothing expected: expected none, got %h",
                     $time, act);
            return;
         end
         want = expected_slots.pop_front();
         compare_field("status",      64'(want.status),   64'(act.status));
         compare_field("dma_addr",    want.dma_addr,      act.dma_addr);
         compare_field("payload_out", want.payload,       act.payload);
         compare_field("queue_out",   64'(want.queue),    64'(act.queue));
         compare_field("tail_index",  64'(want.tail),     64'(act.tail));
         compare_field("sent_count",  64'(want.sent),     64'(act.sent));
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_opcode;
   logic [mqrw_pkg::QID_W-1:0]     req_queue;
   logic [mqrw_pkg::IDX_W-1:0]     req_head_index;
   logic [mqrw_pkg::DATA_W-1:0]    req_payload;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [1:0]                     rsp_status;
   logic [mqrw_pkg::ADDR_W-1:0]    rsp_dma_addr;
   logic [mqrw_pkg::DATA_W-1:0]    rsp_payload_out;
   logic [mqrw_pkg::QID_W-1:0]     rsp_queue_out;
   logic [mqrw_pkg::IDX_W-1:0]     rsp_tail_index;
   logic [mqrw_pkg::CNT_W-1:0]     rsp_sent_count;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [mqrw_pkg::PADDR_W-1:0]   csr_paddr;
   logic [mqrw_pkg::PDATA_W-1:0]   csr_pwdata;
   logic [mqrw_pkg::PDATA_W-1:0]   csr_prdata;
   logic                           csr_pready;

   slot_scoreboard_type            sb;
   bit                             send_burst = 1'b0;
   bit                             take_burst = 1'b0;
   logic [mqrw_pkg::QID_W-1:0]     hot_queue  = '0;
   int unsigned                    cycle_count = 0;

   multi_queue_ring_writer_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_queue       (req_queue),
      .req_head_index  (req_head_index),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_dma_addr    (rsp_dma_addr),
      .rsp_payload_out (rsp_payload_out),
      .rsp_queue_out   (rsp_queue_out),
      .rsp_tail_index  (rsp_tail_index),
      .rsp_sent_count  (rsp_sent_count),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   // Bail out if the block stops moving
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multi_queue_ring_writer_unit_tb: errors");
         $finish;
      end
   end

   // Offer one request transaction after a random gap, hold it until accepted,
   // then hand it to the predictor on the acceptance edge.
   task automatic send_request(mqrw_pkg::opcode_type op, logic [mqrw_pkg::QID_W-1:0] q,
                               logic [mqrw_pkg::IDX_W-1:0] hidx,
                               logic [mqrw_pkg::DATA_W-1:0] data);
      int gap;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : int'($urandom_range(0, 17));
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_queue      <= q;
      req_head_index <= hidx;
      req_payload    <= data;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(op, q, hidx, data);
   endtask

   // Drop valid and hold off until every owed response has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; the register takes the value on
   // the edge that completes the access phase.
   task automatic write_base(int idx, logic [mqrw_pkg::PDATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= mqrw_pkg::PADDR_W'(idx << mqrw_pkg::REG_LSB);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.base[idx] = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_bases(base_pattern_type pat);
      logic [mqrw_pkg::ADDR_W-1:0] v;
      for (int i = 0; i < mqrw_pkg::NUM_REGS; i++) begin
         case (pat)
            BASES_ZERO: v = '0;
            BASES_ONES: v = '1;
            // close enough to the top that deep slots wrap the 64-bit address
            BASES_WRAP: v = {48'hFFFF_FFFF_FFFE, 4'h0, 12'($urandom_range(0, 4095))};
            BASES_MIXED: begin
               if (i == 0) v = '0;
               else if (i[0]) v = '1;
               else v = {$urandom, $urandom};
            end
            default: v = {$urandom, $urandom};
         endcase
         write_base(i, v);
      end
   endtask

   // Hand-picked opening: field extremes, each status, hold/retry/release paths
   task automatic run_directed();
      send_request(mqrw_pkg::OP_MSG,  3'd0, 8'h00, 64'h0);
      send_request(mqrw_pkg::OP_MSG,  3'd7, 8'hFF, '1);
      // head beyond the ring size is stored but never blocks
      send_request(mqrw_pkg::OP_HEAD, 3'd1, 8'hFF, 64'h0);
      send_request(mqrw_pkg::OP_MSG,  3'd1, 8'h55, 64'hA5A5_5A5A_0F0F_F0F0);
      send_request(mqrw_pkg::OP_HEAD, 3'd1, 8'h00, '1);
      // make queue 2 full: its next tail equals the head
      send_request(mqrw_pkg::OP_HEAD, 3'd2, 8'h01, 64'h0);
      send_request(mqrw_pkg::OP_MSG,  3'd2, 8'h00, 64'h1234_5678_9ABC_DEF0);
      // refused while a message waits
      send_request(mqrw_pkg::OP_MSG,  3'd3, 8'hAA, 64'hFFFF_0000_FFFF_0000);
      // head move elsewhere retries the waiting message, still full
      send_request(mqrw_pkg::OP_HEAD, 3'd5, 8'h2A, 64'h0);
      // release it
      send_request(mqrw_pkg::OP_HEAD, 3'd2, 8'h3F, 64'h0);
      send_request(mqrw_pkg::OP_MSG,  3'd2, 8'h00, 64'h8000_0000_0000_0001);
      send_request(mqrw_pkg::OP_HEAD, 3'd2, 8'h03, 64'h0);
      send_request(mqrw_pkg::OP_MSG,  3'd2, 8'h00, 64'h7FFF_FFFF_FFFF_FFFE);
      // release through an out-of-range head
      send_request(mqrw_pkg::OP_HEAD, 3'd2, 8'h80, 64'h0);
      send_request(mqrw_pkg::OP_HEAD, 3'd2, 8'h00, 64'h0);
      send_request(mqrw_pkg::OP_MSG,  3'd4, 8'h00, 64'h0000_0001_0000_0000);
      send_request(mqrw_pkg::OP_MSG,  3'd6, 8'h00, 64'hDEAD_BEEF_CAFE_F00D);
      send_request(mqrw_pkg::OP_HEAD, 3'd3, 8'h7F, 64'h0);
   endtask

   // Mostly messages to one hot queue so its tail laps the ring; head moves
   // are steered to block, clear or stay out of the way.
   task automatic random_request();
      int                          pick;
      logic [mqrw_pkg::QID_W-1:0]  q;
      logic [mqrw_pkg::IDX_W-1:0]  h;
      logic [mqrw_pkg::IDX_W-1:0]  t;
      logic [mqrw_pkg::DATA_W-1:0] data;
      pick = int'($urandom_range(0, 99));
      q    = ($urandom_range(0, 7) != 0) ? hot_queue
                                         : mqrw_pkg::QID_W'($urandom_range(0, 7));
      data = {$urandom, $urandom};
      if ($urandom_range(0, 15) == 0) data = $urandom_range(0, 1) ? '1 : '0;
      if (pick < 60) begin
         send_request(mqrw_pkg::OP_MSG, q, mqrw_pkg::IDX_W'($urandom_range(0, 255)), data);
      end else begin
         if (sb.msg_held && $urandom_range(0, 1) == 1) q = sb.held_queue;
         t = sb.tail[q];
         case ($urandom_range(0, 5))
            // block next slot
            0:       h = (t == mqrw_pkg::IDX_W'(mqrw_pkg::SLOTS - 1)) ? '0 : t + 1'b1;
            // ring empty
            1:       h = t;
            4:       h = mqrw_pkg::IDX_W'($urandom_range(0, 255));
            5:       h = mqrw_pkg::IDX_W'((int'(t) + 2) % mqrw_pkg::SLOTS);
            default: h = mqrw_pkg::IDX_W'($urandom_range(0, mqrw_pkg::SLOTS - 1));
         endcase
         send_request(mqrw_pkg::OP_HEAD, q, h, data);
      end
   endtask

   // Response side: random stalls, check every accepted response in order
   initial begin
      int              stall;
      ring_result_type seen;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
         stall = take_burst ? 0 : int'($urandom_range(0, 17));
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         seen.status   = mqrw_pkg::status_type'(rsp_status);
         seen.dma_addr = rsp_dma_addr;
         seen.payload  = rsp_payload_out;
         seen.queue    = rsp_queue_out;
         seen.tail     = rsp_tail_index;
         seen.sent     = rsp_sent_count;
         sb.check_response(seen);
      end
   end

   initial begin
      base_pattern_type phase_bases [PHASES];
      phase_bases = '{BASES_RANDOM, BASES_ONES, BASES_WRAP, BASES_ZERO, BASES_MIXED,
                      BASES_RANDOM};
      req_valid      = 1'b0;
      req_opcode     = 1'b0;
      req_queue      = '0;
      req_head_index = '0;
      req_payload    = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      sb = new();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_bases(BASES_MIXED);
      run_directed();

      // Each phase: go idle, load a new base setting, then random traffic.
      // The hot queue holds for two phases so its tail wraps.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         load_bases(phase_bases[ph]);
         hot_queue = mqrw_pkg::QID_W'((ph / 2) * 3 + 1);
         repeat (PHASE_ITEMS) random_request();
      end
      drain();

      if (sb.errors == 0)
         $display("multi_queue_ring_writer_unit_tb: clean");
      else
         $display("multi_queue_ring_writer_unit_tb: errors");
      $finish;
   end

endmodule

/* multi_queue_ring_writer_unit.f */
sv/mqrw_pkg.sv
sv/mqrw_table.sv
sv/mqrw_csr.sv
sv/multi_queue_ring_writer_unit.sv
test/multi_queue_ring_writer_unit_tb.sv
